// File: sv/assert_macros.svh
// Assertion macros shared by the receiver window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, ignored while reset is high.
`define SRRW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on the rising clock edge, also during reset.
`define SRRW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRRW_ASSERT(label, clk, rst, prop, msg)
`define SRRW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: sv/srrw_pkg.sv
// Shared types and constants of the selective repeat receiver window.
package srrw_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int WIN_LIMIT  = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
   localparam int SEQ_W      = 32;
   localparam int MAP_W      = 32;
   localparam int MAP_IDX_W  = $clog2(MAP_W);
   localparam int WSIZE_W    = 6;

   localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(8);
   localparam logic [SEQ_W-1:0]   BASE_RESET  = SEQ_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_SLIDE,
      ST_EMIT
   } srrw_state_type;

   // Packet header handed to the window unit.
   typedef struct packed {
      logic             start;
      logic [SEQ_W-1:0] seq;
      logic             last;
   } srrw_cmd_type;

   // Acknowledgement handed back by the window unit.
   typedef struct packed {
      logic             valid;
      logic [SEQ_W-1:0] base;
      logic [MAP_W-1:0] bitmap;
      logic             store;
      logic             done;
   } srrw_res_type;

   // Clamp the programmed window size to 1 .. WIN_LIMIT.
   function automatic logic [WSIZE_W-1:0] eff_window(input logic [WSIZE_W-1:0] wsize);
      logic [WSIZE_W-1:0] w;
      w = wsize;
      if (w == '0) begin
         w = WSIZE_W'(1);
      end
      if (w > WSIZE_W'(WIN_LIMIT)) begin
         w = WSIZE_W'(WIN_LIMIT);
      end
      return w;
   endfunction

endpackage

// File: sv/srrw_if.sv
// Channel interfaces of the receiver window: packet header, acknowledgement, control write.
interface srrw_req_if;
   logic                       valid;
   logic                       ready;
   logic [srrw_pkg::SEQ_W-1:0] sequence_number;
   logic                       is_final;

   modport source (output valid, output sequence_number, output is_final, input ready);
   modport sink   (input valid, input sequence_number, input is_final, output ready);
endinterface

interface srrw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [srrw_pkg::SEQ_W-1:0] ack_base;
   logic [srrw_pkg::MAP_W-1:0] ack_bitmap;
   logic                       store_payload;
   logic                       transfer_done;

   modport source (output valid, output ack_base, output ack_bitmap, output store_payload,
                   output transfer_done, input ready);
   modport sink   (input valid, input ack_base, input ack_bitmap, input store_payload,
                   input transfer_done, output ready);
endinterface

interface srrw_csr_if;
   logic                         valid;
   logic                         ready;
   logic [srrw_pkg::WSIZE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/srrw_window.sv
// Window state and sequencer: marks a packet, then slides the base one place a cycle.
`include "assert_macros.svh"

module srrw_window (
   input  logic                           clock,
   input  logic                           reset,
   input  srrw_pkg::srrw_cmd_type         cmd,
   input  logic [srrw_pkg::WSIZE_W-1:0]   window,
   input  logic                           res_take,
   output logic                           idle,
   output srrw_pkg::srrw_res_type         res
);

   srrw_pkg::srrw_state_type       state_ff, state_in;
   logic [srrw_pkg::SEQ_W-1:0]     seq_ff;
   logic [srrw_pkg::SEQ_W-1:0]     base_ff;
   logic [srrw_pkg::MAP_W-1:0]     bitmap_ff;
   logic [srrw_pkg::SEQ_W-1:0]     final_seq_ff;
   logic                           final_known_ff;
   logic                           store_ff;
   logic [srrw_pkg::SEQ_W-1:0]     offset;
   logic                           in_win;

   // Offset of the packet from the base, modulo 2^32, and window test
   assign offset = seq_ff - base_ff;
   assign in_win = (offset[srrw_pkg::SEQ_W-1:srrw_pkg::WSIZE_W] == '0) &&
                   (offset[srrw_pkg::WSIZE_W-1:0] < window);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srrw_pkg::ST_IDLE: begin
            if (cmd.start) begin
               state_in = srrw_pkg::ST_MARK;
            end
         end
         srrw_pkg::ST_MARK: begin
            if (in_win && (offset == '0)) begin
               state_in = srrw_pkg::ST_SLIDE;
            end else begin
               state_in = srrw_pkg::ST_EMIT;
            end
         end
         srrw_pkg::ST_SLIDE: begin
            if (!bitmap_ff[0]) begin
               state_in = srrw_pkg::ST_EMIT;
            end
         end
         srrw_pkg::ST_EMIT: begin
            if (res_take) begin
               state_in = srrw_pkg::ST_IDLE;
            end
         end
         default: state_in = srrw_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      idle       = (state_ff == srrw_pkg::ST_IDLE);
      res.valid  = (state_ff == srrw_pkg::ST_EMIT);
      res.base   = base_ff;
      res.bitmap = bitmap_ff;
      res.store  = store_ff;
      res.done   = final_known_ff && (base_ff == final_seq_ff + srrw_pkg::SEQ_W'(1));
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srrw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Window state: capture, mark, and shift one place per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= srrw_pkg::BASE_RESET;
         bitmap_ff      <= '0;
         final_seq_ff   <= '0;
         final_known_ff <= 1'b0;
         store_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            srrw_pkg::ST_IDLE: begin
               if (cmd.start) begin
                  seq_ff   <= cmd.seq;
                  store_ff <= 1'b0;
                  if (cmd.last) begin
                     final_seq_ff   <= cmd.seq;
                     final_known_ff <= 1'b1;
                  end
               end
            end
            srrw_pkg::ST_MARK: begin
               if (in_win) begin
                  store_ff  <= 1'b1;
                  bitmap_ff <= bitmap_ff |
                               (srrw_pkg::MAP_W'(1) << offset[srrw_pkg::MAP_IDX_W-1:0]);
               end
            end
            srrw_pkg::ST_SLIDE: begin
               if (bitmap_ff[0]) begin
                  bitmap_ff <= bitmap_ff >> 1;
                  base_ff   <= base_ff + srrw_pkg::SEQ_W'(1);
               end
            end
            srrw_pkg::ST_EMIT: begin
            end
            default: begin
            end
         endcase
      end
   end

   `SRRW_ASSERT_ALWAYS(a_reset_window, clock, reset |=> (base_ff == srrw_pkg::BASE_RESET) && (bitmap_ff == '0) && !final_known_ff, "window not cleared by reset")
   `SRRW_ASSERT(a_slide_step, clock, reset, (state_ff == srrw_pkg::ST_SLIDE) && bitmap_ff[0] |=> base_ff == $past(base_ff) + srrw_pkg::SEQ_W'(1), "base did not advance on slide")
   `SRRW_ASSERT(a_slide_exit, clock, reset, (state_ff == srrw_pkg::ST_SLIDE) && !bitmap_ff[0] |=> (state_ff == srrw_pkg::ST_EMIT) && !bitmap_ff[0], "slide left with base packet marked")
   `SRRW_ASSERT(a_outside_hold, clock, reset, (state_ff == srrw_pkg::ST_MARK) && !in_win |=> $stable(base_ff) && $stable(bitmap_ff) && !store_ff, "window changed by packet outside it")

endmodule

// File: sv/selective_repeat_receiver_window_core.sv
// Selective repeat receiver window: an accepted item passes the window unit states MARK,
// SLIDE (when the base slides past k packets, k up to 32) and EMIT, then its ack is registered.
// One item at a time: a new item is taken only once the window unit is idle again, which
// waits while the acknowledgement register is full and not being taken.
// The acknowledgement register lets the next item start while a result still waits.
// Synchronous active-high reset: base 1, bitmap clear, no final packet, window size 8.
`include "assert_macros.svh"

module selective_repeat_receiver_window_core (
   input  logic        clock,
   input  logic        reset,
   srrw_req_if.sink    req_ch,
   srrw_rsp_if.source  rsp_ch,
   srrw_csr_if.sink    csr_ch
);

   logic [srrw_pkg::WSIZE_W-1:0] wsize_ff;
   logic                         rsp_valid_ff;
   logic [srrw_pkg::SEQ_W-1:0]   rsp_base_ff;
   logic [srrw_pkg::MAP_W-1:0]   rsp_bitmap_ff;
   logic                         rsp_store_ff;
   logic                         rsp_done_ff;
   logic                         idle;
   logic                         res_take;
   srrw_pkg::srrw_cmd_type       cmd;
   srrw_pkg::srrw_res_type       res;

   // Control register write, always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= srrw_pkg::WSIZE_RESET;
      end else if (csr_ch.valid) begin
         wsize_ff <= csr_ch.data;
      end
   end

   // Hand accepted items to the window unit
   assign req_ch.ready = idle;
   assign cmd.start    = req_ch.valid && idle;
   assign cmd.seq      = req_ch.sequence_number;
   assign cmd.last     = req_ch.is_final;

   srrw_window u_window (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .window   (srrw_pkg::eff_window(wsize_ff)),
      .res_take (res_take),
      .idle     (idle),
      .res      (res)
   );

   // Acknowledgement register: load when empty or being drained
   assign res_take = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take && res.valid) begin
         rsp_base_ff   <= res.base;
         rsp_bitmap_ff <= res.bitmap;
         rsp_store_ff  <= res.store;
         rsp_done_ff   <= res.done;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ack_base      = rsp_base_ff;
   assign rsp_ch.ack_bitmap    = rsp_bitmap_ff;
   assign rsp_ch.store_payload = rsp_store_ff;
   assign rsp_ch.transfer_done = rsp_done_ff;

   `SRRW_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid_ff && !rsp_ch.ready |=>
         rsp_valid_ff && $stable(rsp_base_ff) && $stable(rsp_bitmap_ff),
      "acknowledgement dropped while stalled")
   `SRRW_ASSERT(a_busy_no_accept, clock, reset,
      req_ch.valid && req_ch.ready |=> !req_ch.ready,
      "item accepted while window unit busy")
   `SRRW_ASSERT(a_result_loaded, clock, reset,
      res.valid && res_take |=> rsp_valid_ff && req_ch.ready,
      "finished item not moved to acknowledgement register")

endmodule
